[sv/euq_pkg.sv]
// Shared types and constants for the Euler-angle to quaternion pipeline.
// No dependencies.
package euq_pkg;

    localparam int CORDIC_ITERS = 30;
    // Datapath width of the CORDIC and Q.30 values (sign, two integer bits, guard bits).
    localparam int CW = 34;
    localparam int PW = 2 * CW;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [PW-1:0] t_pw;

    // CORDIC gain 0.607252935 in Q2.30
    localparam t_cw CORDIC_GAIN = 34'sd652032874;

    // Quadrant codes from the top two bits of the half-angle phase
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // atan(2^-i) as a 32-bit binary angle
    localparam t_cw ATAN_TBL [CORDIC_ITERS] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
        34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
        34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215,
        34'sd2608, 34'sd1304, 34'sd652, 34'sd326, 34'sd163,
        34'sd81, 34'sd41, 34'sd20, 34'sd10, 34'sd5, 34'sd3, 34'sd1
    };

endpackage

[sv/euler_to_quaternion.sv]
// Euler angles (binary angle) to rotation quaternion qy*qx*qz, Q1.FRAC_BITS out.
// Depends on euq_pkg.
//
// Usage:
//   Input channel:  i_valid / o_ready, payload i_angle_x, i_angle_y, i_angle_z.
//   Output channel: o_valid / i_ready, payload o_quat_x/y/z/w.
//   A transfer happens on a rising edge with valid and ready both high.
//   Data passes through 36 register stages (one init stage, 30 CORDIC
//   iteration stages, quadrant fix-up, two stages for the pair products, one
//   for the final products, one for sum/round/saturate) before o_valid rises;
//   the transfer edge itself loads the init stage.
//   Throughput: one item per cycle while no stall holds the pipeline; each
//   CORDIC iteration and each multiply has its own register stage.
//   Stall: every stage holds when full and the stage after it cannot take
//   its data; empty stages keep filling, so bubbles get squeezed out.
//   o_ready is high whenever the output register is empty or being read.
//   Reset: synchronous, active low; clears all stage valid bits. Data
//   registers are not reset.
//   The three angles run in three parallel CORDIC lanes.
module euler_to_quaternion import euq_pkg::*; #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ANGLE_BITS-1:0] i_angle_x,
    input  logic [ANGLE_BITS-1:0] i_angle_y,
    input  logic [ANGLE_BITS-1:0] i_angle_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [FRAC_BITS:0] o_quat_x,
    output logic signed [FRAC_BITS:0] o_quat_y,
    output logic signed [FRAC_BITS:0] o_quat_z,
    output logic signed [FRAC_BITS:0] o_quat_w
);

    localparam int NST   = CORDIC_ITERS + 6;
    localparam int S_MAP = CORDIC_ITERS + 1;
    localparam int S_PR  = CORDIC_ITERS + 2;
    localparam int S_PQ  = CORDIC_ITERS + 3;
    localparam int S_FR  = CORDIC_ITERS + 4;
    localparam int S_OUT = CORDIC_ITERS + 5;
    localparam int OW    = FRAC_BITS + 1;
    localparam int SW    = PW + 2;

    localparam t_pw PAIR_RND = t_pw'(64'sd1 <<< 29);
    localparam logic signed [SW-1:0] FIN_RND = SW'(64'sd1 <<< (59 - FRAC_BITS));
    localparam logic signed [SW-1:0] QHI = SW'((64'sd1 <<< FRAC_BITS) - 64'sd1);
    localparam logic signed [SW-1:0] QLO = SW'(-(64'sd1 <<< FRAC_BITS));

    logic [NST-1:0] r_v;
    logic [NST:0]   w_en;

    // stage enables: a stage loads when empty or when its content moves on
    always_comb begin
        w_en[NST] = i_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---- init: half-angle phase, quadrant split ----
    logic [ANGLE_BITS-1:0] w_ang [3];
    logic [ANGLE_BITS+31:0] w_sh [3];
    logic [31:0] w_p [3];

    assign w_ang[0] = i_angle_x;
    assign w_ang[1] = i_angle_y;
    assign w_ang[2] = i_angle_z;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_sh[l] = {w_ang[l], 32'b0} >> (ANGLE_BITS + 1);
            w_p[l]  = w_sh[l][31:0];
        end
    end

    t_cw        r_x [CORDIC_ITERS+1][3];
    t_cw        r_y [CORDIC_ITERS+1][3];
    t_cw        r_z [CORDIC_ITERS+1][3];
    logic [1:0] r_q [CORDIC_ITERS+1][3];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int l = 0; l < 3; l++) begin
                r_x[0][l] <= CORDIC_GAIN;
                r_y[0][l] <= '0;
                r_z[0][l] <= t_cw'({1'b0, w_p[l][29:0]});
                r_q[0][l] <= w_p[l][31:30];
            end
        end
    end

    // ---- CORDIC: one iteration per stage ----
    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (w_en[k+1]) begin
                for (int l = 0; l < 3; l++) begin
                    if (!r_z[k][l][CW-1]) begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - ATAN_TBL[k];
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + ATAN_TBL[k];
                    end
                    r_q[k+1][l] <= r_q[k][l];
                end
            end
        end
    end

    // ---- quadrant fix-up ----
    t_cw r_c [3];
    t_cw r_s [3];

    always_ff @(posedge i_clk) begin
        if (w_en[S_MAP]) begin
            for (int l = 0; l < 3; l++) begin
                case (r_q[CORDIC_ITERS][l])
                    QUAD_0: begin
                        r_c[l] <= r_x[CORDIC_ITERS][l];
                        r_s[l] <= r_y[CORDIC_ITERS][l];
                    end
                    QUAD_1: begin
                        r_c[l] <= -r_y[CORDIC_ITERS][l];
                        r_s[l] <= r_x[CORDIC_ITERS][l];
                    end
                    QUAD_2: begin
                        r_c[l] <= -r_x[CORDIC_ITERS][l];
                        r_s[l] <= -r_y[CORDIC_ITERS][l];
                    end
                    default: begin
                        r_c[l] <= r_y[CORDIC_ITERS][l];
                        r_s[l] <= -r_x[CORDIC_ITERS][l];
                    end
                endcase
            end
        end
    end

    // ---- pair products: 0 cy*cx, 1 sy*sx, 2 cy*sx, 3 sy*cx ----
    t_pw r_pp [4];
    t_cw r_cz1, r_sz1, r_cz2, r_sz2;

    always_ff @(posedge i_clk) begin
        if (w_en[S_PR]) begin
            r_pp[0] <= r_c[1] * r_c[0];
            r_pp[1] <= r_s[1] * r_s[0];
            r_pp[2] <= r_c[1] * r_s[0];
            r_pp[3] <= r_s[1] * r_c[0];
            r_cz1   <= r_c[2];
            r_sz1   <= r_s[2];
        end
    end

    t_cw r_pq [4];

    always_ff @(posedge i_clk) begin
        if (w_en[S_PQ]) begin
            for (int j = 0; j < 4; j++) begin
                r_pq[j] <= CW'((r_pp[j] + PAIR_RND) >>> 30);
            end
            r_cz2 <= r_cz1;
            r_sz2 <= r_sz1;
        end
    end

    // ---- final products ----
    t_pw r_fp [8];

    always_ff @(posedge i_clk) begin
        if (w_en[S_FR]) begin
            r_fp[0] <= r_pq[2] * r_cz2;
            r_fp[1] <= r_pq[3] * r_sz2;
            r_fp[2] <= r_pq[3] * r_cz2;
            r_fp[3] <= r_pq[2] * r_sz2;
            r_fp[4] <= r_pq[0] * r_sz2;
            r_fp[5] <= r_pq[1] * r_cz2;
            r_fp[6] <= r_pq[0] * r_cz2;
            r_fp[7] <= r_pq[1] * r_sz2;
        end
    end

    // ---- sum, round half up, saturate ----
    logic signed [SW-1:0] w_sum [4];
    logic signed [SW-1:0] w_rnd [4];
    logic signed [SW-1:0] w_sat [4];
    logic signed [OW-1:0] r_qo  [4];

    always_comb begin
        w_sum[0] = SW'(r_fp[0]) + SW'(r_fp[1]);
        w_sum[1] = SW'(r_fp[2]) - SW'(r_fp[3]);
        w_sum[2] = SW'(r_fp[4]) - SW'(r_fp[5]);
        w_sum[3] = SW'(r_fp[6]) + SW'(r_fp[7]);
        for (int j = 0; j < 4; j++) begin
            w_rnd[j] = (w_sum[j] + FIN_RND) >>> (60 - FRAC_BITS);
            if (w_rnd[j] > QHI) begin
                w_sat[j] = QHI;
            end else if (w_rnd[j] < QLO) begin
                w_sat[j] = QLO;
            end else begin
                w_sat[j] = w_rnd[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[S_OUT]) begin
            for (int j = 0; j < 4; j++) begin
                r_qo[j] <= w_sat[j][OW-1:0];
            end
        end
    end

    assign o_ready  = w_en[0];
    assign o_valid  = r_v[S_OUT];
    assign o_quat_x = r_qo[0];
    assign o_quat_y = r_qo[1];
    assign o_quat_z = r_qo[2];
    assign o_quat_w = r_qo[3];

endmodule

[sv/euq_checker.sv]
// Port-level checks for euler_to_quaternion, bound to the top level.
// Depends on the top level's ports only.
module euq_checker #(
    parameter int FRAC_BITS  = 15
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_ready,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic signed [FRAC_BITS:0] o_quat_x,
    input logic signed [FRAC_BITS:0] o_quat_y,
    input logic signed [FRAC_BITS:0] o_quat_z,
    input logic signed [FRAC_BITS:0] o_quat_w
);

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("o_valid after reset");

    // an empty output register never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // a draining output never blocks the input
    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("input blocked while output drains");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_quat_x) && $stable(o_quat_y)
            && $stable(o_quat_z) && $stable(o_quat_w))
        else $error("stalled result changed");

endmodule

bind euler_to_quaternion euq_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_euq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_quat_x(o_quat_x),
    .o_quat_y(o_quat_y),
    .o_quat_z(o_quat_z),
    .o_quat_w(o_quat_w)
);
